// File: hw/rtl/mie_pkg.sv
package mie_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;

  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6;
  localparam logic [5:0] FN_SRAV = 6'd7;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_JALR = 6'd9;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  localparam logic [31:0] SEGMENT_MASK = 32'hF800_0000;
  localparam logic [31:0] LIMIT_RESET  = 32'd1023;
  localparam logic [4:0]  LINK_REG     = 5'd31;

  // register index on the config port
  localparam logic CFG_REG_LIMIT = 1'b0;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        out_of_range;
  } exec_res_t;

endpackage

// File: hw/rtl/mie_exec.sv
module mie_exec (
  input  logic [31:0]         instruction,
  input  logic [31:0]         rs_val,
  input  logic [31:0]         rt_val,
  input  logic [31:0]         pc,
  input  logic [31:0]         active_limit,
  output mie_pkg::exec_res_t  res
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [15:0] imm;
  logic [31:0] imm_sx;
  logic [31:0] imm_zx;
  logic [31:0] br_pc;

  assign op     = instruction[31:26];
  assign fn     = instruction[5:0];
  assign rt     = instruction[20:16];
  assign rd     = instruction[15:11];
  assign sa     = instruction[10:6];
  assign imm    = instruction[15:0];
  assign imm_sx = {{16{imm[15]}}, imm};
  assign imm_zx = {16'd0, imm};
  assign br_pc  = pc + imm_sx;

  always_comb begin
    logic        wr;
    logic [4:0]  dst;
    logic [31:0] val;
    logic [31:0] npc;
    logic [31:0] inc;

    wr  = 1'b0;
    dst = 5'd0;
    val = 32'd0;
    npc = pc;

    unique case (op)
      mie_pkg::OP_SPECIAL: begin
        wr  = 1'b1;
        dst = rd;
        unique case (fn)
          mie_pkg::FN_SLL:  val = rs_val << sa;
          mie_pkg::FN_SRL:  val = rs_val >> sa;
          mie_pkg::FN_SRA:  val = 32'($signed(rs_val) >>> sa);
          mie_pkg::FN_SLLV: val = rs_val << rt_val[4:0];
          mie_pkg::FN_SRLV: val = rs_val >> rt_val[4:0];
          mie_pkg::FN_SRAV: val = 32'($signed(rs_val) >>> rt_val[4:0]);
          mie_pkg::FN_JR: begin
            wr  = 1'b0;
            npc = rs_val;
          end
          mie_pkg::FN_JALR: begin
            val = pc;
            npc = rs_val;
          end
          mie_pkg::FN_ADD:  val = rs_val + rt_val;
          mie_pkg::FN_SUB:  val = rs_val - rt_val;
          mie_pkg::FN_AND:  val = rs_val & rt_val;
          mie_pkg::FN_OR:   val = rs_val | rt_val;
          mie_pkg::FN_XOR:  val = rs_val ^ rt_val;
          mie_pkg::FN_NOR:  val = ~(rs_val | rt_val);
          mie_pkg::FN_SLT:  val = {31'd0, $signed(rs_val) < $signed(rt_val)};
          mie_pkg::FN_SLTU: val = {31'd0, rs_val < rt_val};
          default:          wr  = 1'b0;
        endcase
      end
      mie_pkg::OP_REGIMM: begin
        // bgezal: link and branch only when taken
        if (!rs_val[31]) begin
          wr  = 1'b1;
          dst = mie_pkg::LINK_REG;
          val = pc;
          npc = br_pc;
        end
      end
      mie_pkg::OP_J:     npc = (pc & mie_pkg::SEGMENT_MASK) | {6'd0, instruction[25:0]};
      mie_pkg::OP_BEQ:   if (rs_val == rt_val) npc = br_pc;
      mie_pkg::OP_BNE:   if (rs_val != rt_val) npc = br_pc;
      mie_pkg::OP_ADDI: begin
        wr = 1'b1; dst = rt; val = rs_val + imm_sx;
      end
      mie_pkg::OP_SLTI: begin
        wr = 1'b1; dst = rt; val = {31'd0, $signed(rs_val) < $signed(imm_sx)};
      end
      mie_pkg::OP_SLTIU: begin
        wr = 1'b1; dst = rt; val = {31'd0, rs_val < imm_sx};
      end
      mie_pkg::OP_ANDI: begin
        wr = 1'b1; dst = rt; val = rs_val & imm_zx;
      end
      mie_pkg::OP_ORI: begin
        wr = 1'b1; dst = rt; val = rs_val | imm_zx;
      end
      mie_pkg::OP_XORI: begin
        wr = 1'b1; dst = rt; val = rs_val ^ imm_zx;
      end
      mie_pkg::OP_LUI: begin
        wr = 1'b1; dst = rt; val = {imm, 16'd0};
      end
      default: ;
    endcase

    // with no write, or a write to r0 (hardwired), drop the write and clear the report
    if (!wr || dst == 5'd0) begin
      wr  = 1'b0;
      dst = 5'd0;
      val = 32'd0;
    end

    inc = npc + 32'd1;
    res.reg_write   = wr;
    res.dest_reg    = dst;
    res.write_value = val;
    if (inc > active_limit) begin
      res.out_of_range = 1'b1;
      res.next_pc      = npc;
    end else begin
      res.out_of_range = 1'b0;
      res.next_pc      = inc;
    end
  end

endmodule

// File: hw/rtl/mips_integer_execute_step.sv
// Flow: an accepted word is registered for execute, then its result is registered
// into the output register behind out_tvalid. Throughput: one instruction per cycle
// while the output is not stalled; the register file has a registered read and a
// one-entry bypass of the previous write, so dependent words need no stall.
// Reset: pc clears to zero, all registers read as zero, active_limit returns to 1023.
module mips_integer_execute_step (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: instruction[31:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // out_tdata: next_pc[31:0], reg_write[32], dest_reg[37:33], write_value[69:38],
  //            out_of_range[70], zero pad[71]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               in_fire;
  logic               ex_fire;
  logic               ex_vld_r;
  logic [31:0]        ex_ins_r;
  logic [31:0]        rd_a_r;
  logic [31:0]        rd_b_r;
  logic [31:0]        op_a;
  logic [31:0]        op_b;
  logic [31:0]        pc_r;
  logic [31:0]        limit_r;
  logic               out_vld_r;
  mie_pkg::exec_res_t res;
  mie_pkg::exec_res_t out_r;

  logic [31:0]        rf_mem [32];
  logic [31:0]        rf_vld_r;
  logic               byp_vld_r;
  logic [4:0]         byp_addr_r;
  logic [31:0]        byp_data_r;

  assign ex_fire   = ex_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !ex_vld_r || ex_fire;
  assign in_fire   = in_tvalid && in_tready;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == mie_pkg::CFG_REG_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mie_pkg::LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == mie_pkg::CFG_REG_LIMIT) begin
      limit_r <= cfg_pwdata;
    end
  end

  // register file: read at accept, written when the instruction retires
  always_ff @(posedge clk) begin
    if (ex_fire && res.reg_write) begin
      rf_mem[res.dest_reg] <= res.write_value;
    end
    if (in_fire) begin
      rd_a_r   <= rf_vld_r[in_tdata[25:21]] ? rf_mem[in_tdata[25:21]] : 32'd0;
      rd_b_r   <= rf_vld_r[in_tdata[20:16]] ? rf_mem[in_tdata[20:16]] : 32'd0;
      ex_ins_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r  <= '0;
      byp_vld_r <= 1'b0;
    end else if (ex_fire) begin
      byp_vld_r <= res.reg_write;
      if (res.reg_write) begin
        rf_vld_r[res.dest_reg] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      byp_addr_r <= res.dest_reg;
      byp_data_r <= res.write_value;
    end
  end

  // the read happened at the edge the previous word retired, so it may be stale
  assign op_a = (byp_vld_r && byp_addr_r == ex_ins_r[25:21]) ? byp_data_r : rd_a_r;
  assign op_b = (byp_vld_r && byp_addr_r == ex_ins_r[20:16]) ? byp_data_r : rd_b_r;

  mie_exec u_exec (
    .instruction  (ex_ins_r),
    .rs_val       (op_a),
    .rt_val       (op_b),
    .pc           (pc_r),
    .active_limit (limit_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= 32'd0;
    end else begin
      if (in_fire) begin
        ex_vld_r <= 1'b1;
      end else if (ex_fire) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_fire) begin
        out_vld_r <= 1'b1;
        pc_r      <= res.next_pc;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.out_of_range, out_r.write_value, out_r.dest_reg,
                       out_r.reg_write, out_r.next_pc};

endmodule

// File: hw/rtl/mie_chk.sv
module mie_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a stalled result word must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no write reported means destination and value are both clear
  a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[37:33] == 5'd0 && out_tdata[69:38] == 32'd0)
    else $error("destination or value set without a write");

  // r0 is never reported as written
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[37:33] != 5'd0)
    else $error("write to r0 reported");

  // input only backs up behind a stalled result word
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with the output free");

  // nothing is presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind mips_integer_execute_step mie_chk u_mie_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
